// ===== hdl/litr_pkg.sv =====
`timescale 1ns / 1ps
package litr_pkg;

    localparam int COUNT_WIDTH_DEF = 32;

    localparam int CMD_WIDTH   = 2;
    localparam int INDEX_WIDTH = 6;
    localparam int DATA_WIDTH  = 32;
    localparam int VEC_WIDTH   = 8;
    localparam int IN_TDATA_WIDTH  = 40;
    localparam int OUT_TDATA_WIDTH = 40;

    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    localparam logic [INDEX_WIDTH-1:0] IDX_EOI      = 6'h0B;
    localparam logic [INDEX_WIDTH-1:0] IDX_SPURIOUS = 6'h0F;
    localparam logic [INDEX_WIDTH-1:0] IDX_TIMER    = 6'h32;
    localparam logic [INDEX_WIDTH-1:0] IDX_INITIAL  = 6'h38;
    localparam logic [INDEX_WIDTH-1:0] IDX_CURRENT  = 6'h39;
    localparam logic [INDEX_WIDTH-1:0] IDX_DIVIDE   = 6'h3E;

    localparam logic [8:0] SPURIOUS_RESET = 9'h0FF;
    localparam logic [1:0] MODE_PERIODIC  = 2'd1;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] read_data;
        logic                  irq_valid;
        logic [VEC_WIDTH-1:0]  irq_vector;
    } result_t;

    // divide code bits 3,1,0; all ones divides by one
    function automatic logic [7:0] divisor(input logic [3:0] code);
        logic [2:0] c;
        c = {code[3], code[1], code[0]};
        if (c == 3'b111)
            return 8'd1;
        return 8'd2 << c;
    endfunction

endpackage

// ===== hdl/litr_engine.sv =====
`timescale 1ns / 1ps
module litr_engine
    import litr_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [CMD_WIDTH-1:0]   command,
    input  logic [INDEX_WIDTH-1:0] reg_index,
    input  logic [DATA_WIDTH-1:0]  write_data,
    output result_t                result
);

    logic [VEC_WIDTH-1:0]   vector_reg,   vector_next;
    logic                   masked_reg,   masked_next;
    logic [1:0]             mode_reg,     mode_next;
    logic [COUNT_WIDTH-1:0] reload_reg,   reload_next;
    logic [COUNT_WIDTH-1:0] down_reg,     down_next;
    logic [3:0]             divide_reg,   divide_next;
    logic [6:0]             prescale_reg, prescale_next;
    logic [8:0]             spurious_reg, spurious_next;
    logic                   pending_reg,  pending_next;
    logic                   insvc_reg,    insvc_next;

    logic [6:0]             pre_inc;
    logic                   fire;
    logic [COUNT_WIDTH-1:0] down_dec;
    logic [COUNT_WIDTH-1:0] wr_count;
    logic [63:0]            reload_wide;
    logic [63:0]            down_wide;
    logic                   deliver;

    assign pre_inc     = prescale_reg + 7'd1;
    assign fire        = (pre_inc == 7'd0) || ({1'b0, pre_inc} >= divisor(divide_reg));
    assign down_dec    = down_reg - COUNT_WIDTH'(1);
    assign wr_count    = COUNT_WIDTH'(write_data);
    assign reload_wide = 64'(reload_reg);
    assign down_wide   = 64'(down_reg);

    always_comb
    begin
        vector_next   = vector_reg;
        masked_next   = masked_reg;
        mode_next     = mode_reg;
        reload_next   = reload_reg;
        down_next     = down_reg;
        divide_next   = divide_reg;
        prescale_next = prescale_reg;
        spurious_next = spurious_reg;
        pending_next  = pending_reg;
        insvc_next    = insvc_reg;
        result        = '0;

        case (cmd_t'(command))
            CMD_TICK:
            begin
                if (down_reg != '0)
                begin
                    prescale_next = pre_inc;
                    if (fire)
                    begin
                        prescale_next = 7'd0;
                        down_next     = down_dec;
                        if (down_dec == '0)
                        begin
                            if (!masked_reg && spurious_reg[8])
                                pending_next = 1'b1;
                            if (mode_reg == MODE_PERIODIC)
                                down_next = reload_reg;
                        end
                    end
                end
            end
            CMD_WRITE:
            begin
                case (reg_index)
                    IDX_EOI:
                        insvc_next = 1'b0;
                    IDX_SPURIOUS:
                    begin
                        spurious_next = write_data[8:0];
                        if (!write_data[8])
                            masked_next = 1'b1;
                    end
                    IDX_TIMER:
                    begin
                        vector_next = write_data[7:0];
                        masked_next = write_data[16] | ~spurious_reg[8];
                        mode_next   = write_data[18:17];
                    end
                    IDX_INITIAL:
                    begin
                        reload_next   = wr_count;
                        down_next     = wr_count;
                        prescale_next = 7'd0;
                    end
                    IDX_DIVIDE:
                        divide_next = {write_data[3], 1'b0, write_data[1:0]};
                    default:
                    begin
                    end
                endcase
            end
            CMD_READ:
            begin
                case (reg_index)
                    IDX_SPURIOUS:
                        result.read_data = {23'd0, spurious_reg};
                    IDX_TIMER:
                        result.read_data = {13'd0, mode_reg, masked_reg, 3'd0, pending_reg,
                                            4'd0, vector_reg};
                    IDX_INITIAL:
                        result.read_data = reload_wide[31:0];
                    IDX_CURRENT:
                        result.read_data = down_wide[31:0];
                    IDX_DIVIDE:
                        result.read_data = {28'd0, divide_reg};
                    default:
                        result.read_data = '0;
                endcase
            end
            default:
            begin
            end
        endcase

        // delivery after the request's own effect
        deliver = pending_next && !insvc_next && spurious_next[8];
        if (deliver)
        begin
            pending_next      = 1'b0;
            insvc_next        = 1'b1;
            result.irq_valid  = 1'b1;
            result.irq_vector = vector_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vector_reg   <= '0;
            masked_reg   <= 1'b1;
            mode_reg     <= 2'd0;
            reload_reg   <= '0;
            down_reg     <= '0;
            divide_reg   <= 4'd0;
            prescale_reg <= 7'd0;
            spurious_reg <= SPURIOUS_RESET;
            pending_reg  <= 1'b0;
            insvc_reg    <= 1'b0;
        end
        else if (accept)
        begin
            vector_reg   <= vector_next;
            masked_reg   <= masked_next;
            mode_reg     <= mode_next;
            reload_reg   <= reload_next;
            down_reg     <= down_next;
            divide_reg   <= divide_next;
            prescale_reg <= prescale_next;
            spurious_reg <= spurious_next;
            pending_reg  <= pending_next;
            insvc_reg    <= insvc_next;
        end
    end

endmodule

// ===== hdl/local_interrupt_timer_registers.sv =====
`timescale 1ns / 1ps
// the result is registered and valid in the cycle after its request is accepted
// throughput: one request per cycle while s_axis_tready is high
// ready stays high while the result register is empty or being taken
// reset (rst_n low, asynchronous): timer masked, one-shot, counters zero,
// divide by two, controller disabled, no interrupt pending or in service
module local_interrupt_timer_registers
    import litr_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata,  // reg_index[5:0], write_data[37:6]
    input  logic [CMD_WIDTH-1:0]       s_axis_tuser,  // command[1:0]
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata,  // read_data[31:0], irq_vector[39:32]
    output logic                       m_axis_tuser   // irq_valid
);

    logic    accept;
    logic    out_valid_reg;
    result_t out_reg;
    result_t result;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    litr_engine #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .command    (s_axis_tuser),
        .reg_index  (s_axis_tdata[5:0]),
        .write_data (s_axis_tdata[37:6]),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.irq_vector, out_reg.read_data};
    assign m_axis_tuser  = out_reg.irq_valid;

endmodule

// ===== hdl/litr_checker.sv =====
`timescale 1ns / 1ps
module litr_checker
    import litr_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       s_axis_tvalid,
    input logic                       s_axis_tready,
    input logic [CMD_WIDTH-1:0]       s_axis_tuser,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata,
    input logic                       m_axis_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // every accepted request gives a result next cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("request without result");

    // empty output stage never blocks input
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // no interrupt, no vector
    a_vec_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[39:32] == 8'd0)
        else $error("vector without interrupt");

    // only reads return data
    a_read_only: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser != CMD_READ |=>
            m_axis_tdata[31:0] == 32'd0)
        else $error("data on non-read request");

endmodule

bind local_interrupt_timer_registers litr_checker u_litr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== verif/local_interrupt_timer_registers_tb.sv =====
`timescale 1ns / 1ps
module local_interrupt_timer_registers_tb;
    import litr_pkg::*;

    localparam logic [CMD_WIDTH-1:0]   CMD_UNDEFINED = 2'd3;
    localparam logic [INDEX_WIDTH-1:0] IDX_UNMAPPED  = 6'h3F;
    localparam logic [31:0] TIMER_PERIODIC = 32'h0002_0000;
    localparam logic [31:0] DIVIDE_BY_ONE  = 32'h0000_000B;
    localparam int RANDOM_ITEMS = 1800;
    localparam int GAP_MAX      = 12;
    localparam int DRAIN_CYCLES = 10;
    localparam int TICK_CAP     = 80;

    logic                       clk;
    logic                       rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata;  // reg_index, write_data
    logic [CMD_WIDTH-1:0]       s_axis_tuser;  // command
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata;  // read_data, irq_vector
    logic                       m_axis_tuser;  // irq_valid

    // timer state as software sees it
    logic [7:0]  tm_vector;
    logic        tm_masked;
    logic [1:0]  tm_mode;
    logic [31:0] tm_reload;
    logic [31:0] tm_count;
    logic [3:0]  tm_divide;
    logic [6:0]  tm_prescale;
    logic [8:0]  tm_spurious;
    logic        tm_pending;
    logic        tm_in_service;

    result_t timer_replies_q[$];
    int      mismatch_count;
    int      items_sent;
    bit      idle_quiet;

    local_interrupt_timer_registers u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("local_interrupt_timer_registers_tb: done, errors");
        $finish;
    end

    function automatic int count_divisor(input logic [3:0] code);
        logic [2:0] sel;
        sel = {code[3], code[1], code[0]};
        if (sel == 3'b111)
            return 1;
        return 1 << (int'(sel) + 1);
    endfunction

    function automatic void reset_timer_state();
        tm_vector     = '0;
        tm_masked     = 1'b1;
        tm_mode       = '0;
        tm_reload     = '0;
        tm_count      = '0;
        tm_divide     = '0;
        tm_prescale   = '0;
        tm_spurious   = SPURIOUS_RESET;
        tm_pending    = 1'b0;
        tm_in_service = 1'b0;
    endfunction

    function automatic void timer_tick();
        logic [7:0] next_pre;
        if (tm_count == '0)
            return;
        next_pre = {1'b0, tm_prescale} + 8'd1;
        if (int'(next_pre) < count_divisor(tm_divide))
        begin
            tm_prescale = next_pre[6:0];
            return;
        end
        tm_prescale = '0;
        tm_count = tm_count - 32'd1;
        if (tm_count != '0)
            return;
        if (!tm_masked && tm_spurious[8])
            tm_pending = 1'b1;
        if (tm_mode == MODE_PERIODIC)
            tm_count = tm_reload;
    endfunction

    function automatic void register_write(input logic [5:0] idx, input logic [31:0] data);
        case (idx)
            IDX_EOI:
                tm_in_service = 1'b0;
            IDX_SPURIOUS:
            begin
                tm_spurious = data[8:0];
                if (!tm_spurious[8])
                    tm_masked = 1'b1;
            end
            IDX_TIMER:
            begin
                tm_vector = data[7:0];
                tm_masked = data[16] | ~tm_spurious[8];
                tm_mode   = data[18:17];
            end
            IDX_INITIAL:
            begin
                tm_reload   = data;
                tm_count    = data;
                tm_prescale = '0;
            end
            IDX_DIVIDE:
                tm_divide = {data[3], 1'b0, data[1:0]};
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] register_read(input logic [5:0] idx);
        case (idx)
            IDX_SPURIOUS: return {23'd0, tm_spurious};
            IDX_TIMER:    return {13'd0, tm_mode, tm_masked, 3'd0, tm_pending, 4'd0, tm_vector};
            IDX_INITIAL:  return tm_reload;
            IDX_CURRENT:  return tm_count;
            IDX_DIVIDE:   return {28'd0, tm_divide};
            default:      return '0;
        endcase
    endfunction

    function automatic result_t predict_timer_reply(input logic [1:0] cmd, input logic [5:0] idx,
                                                    input logic [31:0] data);
        result_t reply;
        reply = '0;
        case (cmd)
            CMD_TICK:  timer_tick();
            CMD_WRITE: register_write(idx, data);
            CMD_READ:  reply.read_data = register_read(idx);
            default: ;
        endcase
        // delivery after the request's own effect
        if (tm_pending && !tm_in_service && tm_spurious[8])
        begin
            tm_pending       = 1'b0;
            tm_in_service    = 1'b1;
            reply.irq_valid  = 1'b1;
            reply.irq_vector = tm_vector;
        end
        return reply;
    endfunction

    function automatic logic [5:0] known_index();
        case ($urandom_range(0, 5))
            0:       return IDX_EOI;
            1:       return IDX_SPURIOUS;
            2:       return IDX_TIMER;
            3:       return IDX_INITIAL;
            4:       return IDX_CURRENT;
            default: return IDX_DIVIDE;
        endcase
    endfunction

    task automatic send_request(input logic [1:0] cmd, input logic [5:0] idx,
                                input logic [31:0] data);
        int gap;
        gap = idle_quiet ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {2'b00, data, idx};
        timer_replies_q.push_back(predict_timer_reply(cmd, idx, data));
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic check_reply(input logic [OUT_TDATA_WIDTH-1:0] tdata, input logic tuser);
        result_t want;
        if (timer_replies_q.size() == 0)
        begin
            $display("%0t: unexpected reply, expected none, got data %h irq %b vector %h",
                     $time, tdata[31:0], tuser, tdata[39:32]);
            mismatch_count++;
            return;
        end
        want = timer_replies_q.pop_front();
        if (tdata[31:0] !== want.read_data)
        begin
            $display("%0t: read_data expected %h, got %h", $time, want.read_data, tdata[31:0]);
            mismatch_count++;
        end
        if (tuser !== want.irq_valid)
        begin
            $display("%0t: irq_valid expected %b, got %b", $time, want.irq_valid, tuser);
            mismatch_count++;
        end
        if (tdata[39:32] !== want.irq_vector)
        begin
            $display("%0t: irq_vector expected %h, got %h", $time, want.irq_vector, tdata[39:32]);
            mismatch_count++;
        end
    endtask

    initial
    begin
        int gap;
        m_axis_tready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            gap = idle_quiet ? 0 : $urandom_range(0, GAP_MAX);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            check_reply(m_axis_tdata, m_axis_tuser);
        end
    end

    task automatic test_reset_values();
        send_request(CMD_READ, IDX_TIMER, '0);
        send_request(CMD_READ, IDX_SPURIOUS, '0);
        send_request(CMD_READ, IDX_DIVIDE, '0);
    endtask

    task automatic test_register_fields();
        // mask held while the controller is disabled
        send_request(CMD_WRITE, IDX_TIMER, '1);
        send_request(CMD_READ, IDX_TIMER, '0);
        send_request(CMD_WRITE, IDX_SPURIOUS, '1);
        send_request(CMD_READ, IDX_SPURIOUS, '0);
        send_request(CMD_WRITE, IDX_DIVIDE, '1);
        send_request(CMD_READ, IDX_DIVIDE, '0);
        send_request(CMD_WRITE, IDX_CURRENT, 32'h1234_5678);
        send_request(CMD_WRITE, IDX_UNMAPPED, '1);
        send_request(CMD_READ, IDX_UNMAPPED, '0);
        send_request(CMD_UNDEFINED, IDX_TIMER, '1);
        send_request(CMD_WRITE, IDX_INITIAL, '1);
        send_request(CMD_READ, IDX_CURRENT, '0);
    endtask

    task automatic test_one_shot_expiry();
        send_request(CMD_WRITE, IDX_TIMER, 32'h0000_00FF);
        send_request(CMD_WRITE, IDX_INITIAL, 32'd2);
        send_request(CMD_TICK, '0, '0);
        send_request(CMD_TICK, '0, '0);
        send_request(CMD_WRITE, IDX_EOI, '0);
    endtask

    task automatic test_periodic_merge();
        send_request(CMD_WRITE, IDX_TIMER, TIMER_PERIODIC | 32'h40);
        send_request(CMD_WRITE, IDX_INITIAL, 32'd1);
        send_request(CMD_TICK, '0, '0);
        send_request(CMD_TICK, '0, '0);
        send_request(CMD_TICK, '0, '0);
        send_request(CMD_READ, IDX_TIMER, '0);
        // eoi write itself delivers the merged interrupt
        send_request(CMD_WRITE, IDX_EOI, '0);
        send_request(CMD_WRITE, IDX_SPURIOUS, '0);
        send_request(CMD_TICK, '0, '0);
    endtask

    task automatic run_timer_sequence();
        logic [31:0] word;
        int          span;
        int          ticks;
        int          pick;
        if ($urandom_range(0, 2) == 0)
        begin
            word = $urandom;
            word[8] = ($urandom_range(0, 5) != 0);
            send_request(CMD_WRITE, IDX_SPURIOUS, word);
        end
        word = $urandom;
        word[16] = ($urandom_range(0, 4) == 0);
        send_request(CMD_WRITE, IDX_TIMER, word);
        if ($urandom_range(0, 1) == 0)
        begin
            word = $urandom;
            if ($urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 2))
                    0:       word[3:0] = DIVIDE_BY_ONE[3:0];
                    1:       word[3:0] = 4'h0;
                    default: word[3:0] = 4'h1;
                endcase
            end
            send_request(CMD_WRITE, IDX_DIVIDE, word);
        end
        case ($urandom_range(0, 9))
            0:       word = '0;
            1:       word = $urandom;
            default: word = $urandom_range(1, 6);
        endcase
        send_request(CMD_WRITE, IDX_INITIAL, word);
        span = (word <= 32'd6) ? int'(word) * count_divisor(tm_divide) : 20;
        ticks = span + $urandom_range(0, 6);
        if (ticks > TICK_CAP)
            ticks = TICK_CAP;
        repeat (ticks)
        begin
            pick = $urandom_range(0, 11);
            case (pick)
                0:       send_request(CMD_WRITE, IDX_EOI, $urandom);
                1:       send_request(CMD_READ, known_index(), $urandom);
                2:       send_request(CMD_READ, IDX_CURRENT, $urandom);
                default: send_request(CMD_TICK, 6'($urandom_range(0, 63)), $urandom);
            endcase
        end
        if ($urandom_range(0, 1) == 0)
            send_request(CMD_WRITE, IDX_EOI, $urandom);
    endtask

    task automatic send_noise();
        logic [1:0] cmd;
        logic [5:0] idx;
        repeat ($urandom_range(2, 6))
        begin
            cmd = 2'($urandom_range(0, 3));
            idx = ($urandom_range(0, 1) == 0) ? known_index() : 6'($urandom_range(0, 63));
            send_request(cmd, idx, $urandom);
        end
    endtask

    task automatic test_random_traffic();
        int start_count;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS)
        begin
            idle_quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 7)
                run_timer_sequence();
            else
                send_noise();
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        idle_quiet     = 1'b0;
        mismatch_count = 0;
        items_sent     = 0;
        reset_timer_state();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_values();
        test_register_fields();
        test_one_shot_expiry();
        test_periodic_merge();
        test_random_traffic();
        s_axis_tvalid <= 1'b0;
        while (timer_replies_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("local_interrupt_timer_registers_tb: done, clean");
        else
            $display("local_interrupt_timer_registers_tb: done, errors");
        $finish;
    end

endmodule
